@@ rtl/ute_pkg.sv @@
// Shared types, codes and character helpers for the text escaper.
`default_nettype none
package ute_pkg;

  // Input transaction payload: one raw text byte.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  // Output transaction payload: one escaped character.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic       end_of_text;
  } out_item_t;

  // Operation codes passed from the front to the back.
  localparam logic [1:0] OP_PASS = 2'd0;  // send the byte as it is
  localparam logic [1:0] OP_DBL  = 2'd1;  // send two backslashes
  localparam logic [1:0] OP_ESC  = 2'd2;  // backslash plus letter or three digits

  // One queued operation.
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last_run;
    logic       eot;
  } op_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int LIST_MAX    = 4;

  // Byte class boundaries and characters.
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7F;
  localparam logic [7:0] LEAD_LO   = 8'hC2;
  localparam logic [7:0] LEAD_END  = 8'hF5;
  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  // Letter escape for a few control bytes, zero when there is none.
  function automatic logic [7:0] esc_letter(input logic [7:0] b);
    case (b)
      8'h07:   return 8'h61;  // a
      8'h08:   return 8'h62;  // b
      8'h0C:   return 8'h66;  // f
      8'h0A:   return 8'h6E;  // n
      8'h0D:   return 8'h72;  // r
      8'h09:   return 8'h74;  // t
      8'h0B:   return 8'h76;  // v
      default: return 8'h00;
    endcase
  endfunction

  // Three decimal digit characters of a byte, hundreds first.
  function automatic logic [23:0] dec_chars(input logic [7:0] b);
    logic [1:0] h;
    logic [6:0] r;
    logic [3:0] t;
    logic [6:0] tens_val;
    logic [3:0] o;
    if (b >= 8'd200) begin
      h = 2'd2;
      r = 7'(b - 8'd200);
    end else if (b >= 8'd100) begin
      h = 2'd1;
      r = 7'(b - 8'd100);
    end else begin
      h = 2'd0;
      r = b[6:0];
    end
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 7'(k * 10)) t = 4'(k);
    end
    tens_val = 7'({3'b000, t} * 7'd10);
    o = 4'(r - tens_val);
    return {CHAR_ZERO + {6'b0, h}, CHAR_ZERO + {4'b0, t}, CHAR_ZERO + {4'b0, o}};
  endfunction

endpackage
`default_nettype wire

@@ rtl/utf8_safe_text_escaper.sv @@
// Top level of the UTF-8 validating text escaper.
//
// Input channel (byte_valid, byte_ready, byte_item) takes one raw text byte per
// transaction; last_byte marks the end of the text. Output channel (char_valid,
// char_ready, char_item) delivers escaped characters, one per transaction, with
// last_of_run on the final character caused by an input byte and end_of_text on
// the final character of the text.
// The front holds lead bytes until their sequence completes or breaks and turns
// each byte into up to four operations, one per cycle while the queue is not
// full, into a four-entry queue. The back expands one character per cycle while
// the receiver is ready: a plain byte gives one character, a backslash two, an
// escape two or four. Sustained input rate is therefore one byte per cycle for
// plain text; for escaped bytes the output character count sets the rate.
// An accepted byte passes the front's operation list, the queue, the current
// operation register and the output register before its first character shows.
// Bytes that only extend a pending sequence give no output until the sequence ends.
// Reset (rst, synchronous) clears any pending sequence and empties the queue.
// When the receiver stalls, the output register holds its character, the queue
// fills and the front then stops accepting bytes; nothing is lost.
`default_nettype none
module utf8_safe_text_escaper import ute_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      byte_valid,
  output logic           byte_ready,
  input  wire in_item_t  byte_item,
  output logic           char_valid,
  input  wire logic      char_ready,
  output out_item_t      char_item
);

  logic push;
  op_t  push_op;
  logic full;
  logic pop;
  op_t  pop_op;
  logic empty;

  // Classification and sequence tracking.
  ute_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .push       (push),
    .push_op    (push_op),
    .full       (full)
  );

  // Operation queue.
  ute_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .pop_op  (pop_op),
    .empty   (empty)
  );

  // Character expansion.
  ute_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .pop_op     (pop_op),
    .pop        (pop),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item)
  );

endmodule
`default_nettype wire

@@ rtl/ute_front.sv @@
// Front end: accepts bytes, tracks pending UTF-8 sequences and issues operations.
`default_nettype none
module ute_front import ute_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     byte_valid,
  output logic          byte_ready,
  input  wire in_item_t byte_item,
  output logic          push,
  output op_t           push_op,
  input  wire logic     full
);

  // Sequence state.
  logic [7:0] held_lead, held_lead_next;
  logic [7:0] held_cont [2];
  logic [7:0] held_cont_next [2];
  logic [1:0] held_count, held_count_next;
  logic [2:0] seq_len, seq_len_next;

  // Operation list of the current transaction.
  op_t        list_op [LIST_MAX];
  op_t        new_op [LIST_MAX];
  logic [2:0] new_n;
  logic [2:0] rem;
  logic [1:0] idx;

  logic       accept;
  logic [7:0] b;
  logic       last;

  assign b      = byte_item.in_byte;
  assign last   = byte_item.last_byte;
  assign push   = (rem != 3'd0) && !full;
  assign push_op = list_op[idx];
  assign byte_ready = (rem == 3'd0) || ((rem == 3'd1) && push);
  assign accept = byte_valid && byte_ready;

  // Build the operation list and next sequence state for the offered byte.
  always_comb begin
    logic       do_fresh;
    logic       is_cont;
    logic [2:0] n;
    n = 3'd0;
    do_fresh = 1'b0;
    is_cont = (b[7:6] == 2'b10);
    held_lead_next = held_lead;
    held_cont_next = held_cont;
    held_count_next = held_count;
    seq_len_next = seq_len;
    for (int i = 0; i < LIST_MAX; i++) begin
      new_op[i] = '{data: 8'h00, kind: OP_PASS, last_run: 1'b0, eot: 1'b0};
    end
    if (seq_len == 3'd0) begin
      do_fresh = 1'b1;
    end else if (is_cont && ({1'b0, held_count} + 3'd2 >= seq_len)) begin
      // Sequence complete: pass every byte through.
      new_op[n[1:0]] = '{data: held_lead, kind: OP_PASS, last_run: 1'b0, eot: 1'b0};
      n = n + 3'd1;
      for (int i = 0; i < 2; i++) begin
        if (2'(i) < held_count) begin
          new_op[n[1:0]] = '{data: held_cont[i], kind: OP_PASS, last_run: 1'b0, eot: 1'b0};
          n = n + 3'd1;
        end
      end
      new_op[n[1:0]] = '{data: b, kind: OP_PASS, last_run: 1'b0, eot: 1'b0};
      n = n + 3'd1;
      held_lead_next = 8'h00;
      held_count_next = 2'd0;
      seq_len_next = 3'd0;
    end else if (is_cont && !last) begin
      // Hold another continuation byte.
      held_cont_next[held_count[0]] = b;
      held_count_next = held_count + 2'd1;
    end else begin
      // Broken or cut off: escape what is held, and the offered byte if it is a continuation byte.
      new_op[n[1:0]] = '{data: held_lead, kind: OP_ESC, last_run: 1'b0, eot: 1'b0};
      n = n + 3'd1;
      for (int i = 0; i < 2; i++) begin
        if (2'(i) < held_count) begin
          new_op[n[1:0]] = '{data: held_cont[i], kind: OP_ESC, last_run: 1'b0, eot: 1'b0};
          n = n + 3'd1;
        end
      end
      held_lead_next = 8'h00;
      held_count_next = 2'd0;
      seq_len_next = 3'd0;
      if (is_cont) begin
        new_op[n[1:0]] = '{data: b, kind: OP_ESC, last_run: 1'b0, eot: 1'b0};
        n = n + 3'd1;
      end else begin
        do_fresh = 1'b1;
      end
    end
    // Treat the byte with no sequence pending.
    if (do_fresh) begin
      if (b < PRINT_LO) begin
        new_op[n[1:0]] = '{data: b, kind: OP_ESC, last_run: 1'b0, eot: 1'b0};
        n = n + 3'd1;
      end else if (b < PRINT_HI) begin
        new_op[n[1:0]] = '{data: b, kind: (b == BACKSLASH) ? OP_DBL : OP_PASS,
                           last_run: 1'b0, eot: 1'b0};
        n = n + 3'd1;
      end else if (b < LEAD_LO || b >= LEAD_END || last) begin
        new_op[n[1:0]] = '{data: b, kind: OP_ESC, last_run: 1'b0, eot: 1'b0};
        n = n + 3'd1;
      end else begin
        held_lead_next = b;
        held_count_next = 2'd0;
        if (b[7:5] == 3'b110) begin
          seq_len_next = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
          seq_len_next = 3'd3;
        end else begin
          seq_len_next = 3'd4;
        end
      end
    end
    // Mark the final operation of the transaction.
    for (int i = 0; i < LIST_MAX; i++) begin
      if (3'(i) == n - 3'd1) begin
        new_op[i].last_run = 1'b1;
        new_op[i].eot = last;
      end
    end
    new_n = n;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead <= 8'h00;
      held_count <= 2'd0;
      seq_len <= 3'd0;
      rem <= 3'd0;
      idx <= 2'd0;
    end else if (accept) begin
      held_lead <= held_lead_next;
      held_count <= held_count_next;
      seq_len <= seq_len_next;
      rem <= new_n;
      idx <= 2'd0;
    end else if (push) begin
      rem <= rem - 3'd1;
      idx <= idx + 2'd1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      held_cont <= held_cont_next;
      list_op <= new_op;
    end
  end

`ifndef SYNTHESIS
  a_held_fits: assert property (@(posedge clk) disable iff (rst)
    (seq_len == 3'd0 && held_count == 2'd0) || (seq_len == 3'd2 && held_count == 2'd0) ||
    (seq_len == 3'd3 && held_count <= 2'd1) || (seq_len == 3'd4 && held_count <= 2'd2))
    else $error("held continuation count does not fit the sequence length");
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (seq_len == 3'd0))
    else $error("sequence still pending after the end of the text");
  a_list_holds: assert property (@(posedge clk) disable iff (rst)
    (rem != 3'd0 && !push) |=> (rem == $past(rem)))
    else $error("operation list changed while the queue was full");
`endif

endmodule
`default_nettype wire

@@ rtl/ute_queue.sv @@
// Small queue of operations between the front and the back.
`default_nettype none
module ute_queue import ute_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire op_t  push_op,
  output logic      full,
  input  wire logic pop,
  output op_t       pop_op,
  output logic      empty
);

  op_t                 mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QPTR_W:0]     count;

  assign full   = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign pop_op = mem[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_op;
  end

endmodule
`default_nettype wire

@@ rtl/ute_back.sv @@
// Back end: expands queued operations into output characters.
`default_nettype none
module ute_back import ute_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic empty,
  input  wire op_t  pop_op,
  output logic      pop,
  output logic      char_valid,
  input  wire logic char_ready,
  output out_item_t char_item
);

  logic        cur_valid;
  op_t         cur_op;
  logic [1:0]  step;
  logic        take;
  logic        advance;
  logic        final_char;
  logic [7:0]  ch;
  logic [7:0]  letter;
  logic [23:0] digits;

  assign take    = !char_valid || char_ready;
  assign advance = cur_valid && take;
  assign pop     = !empty && (!cur_valid || (advance && final_char));
  assign letter  = esc_letter(cur_op.data);
  assign digits  = dec_chars(cur_op.data);

  // Character for the current step of the operation.
  always_comb begin
    ch = cur_op.data;
    final_char = 1'b1;
    case (cur_op.kind)
      OP_PASS: begin
        ch = cur_op.data;
        final_char = 1'b1;
      end
      OP_DBL: begin
        ch = BACKSLASH;
        final_char = (step == 2'd1);
      end
      OP_ESC: begin
        case (step)
          2'd0: ch = BACKSLASH;
          2'd1: ch = (letter != 8'h00) ? letter : digits[23:16];
          2'd2: ch = digits[15:8];
          default: ch = digits[7:0];
        endcase
        final_char = (letter != 8'h00) ? (step == 2'd1) : (step == 2'd3);
      end
      default: begin
        ch = cur_op.data;
        final_char = 1'b1;
      end
    endcase
  end

  // Current operation tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      step <= 2'd0;
    end else if (advance && final_char) begin
      cur_valid <= 1'b0;
    end else if (advance) begin
      step <= step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_op <= pop_op;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (take) begin
      char_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      char_item <= '{out_char: ch, last_of_run: final_char && cur_op.last_run,
                     end_of_text: final_char && cur_op.eot};
    end
  end

endmodule
`default_nettype wire
